### sv/tpa_pkg.sv
// ----------------------------------------------------------------------------
// tpa_pkg - triangle primitive assembler shared definitions
// Index width, primitive mode codes, state and item structs, index helpers.
// ----------------------------------------------------------------------------
package tpa_pkg;

  // Number of low vertex_index bits that take part in assembly (8..32)
  localparam int INDEX_BITS = 16;
  localparam int VIN_BITS   = 16;
  localparam int WORD_BITS  = 32;

  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [WORD_BITS-1:0]  word_t;

  typedef enum logic [1:0] {
    MODE_LIST  = 2'd0,
    MODE_FAN   = 2'd1,
    MODE_STRIP = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;
  localparam logic [1:0] SEEN_BAD  = 2'd3;

  typedef struct packed {
    index_t     fan_anchor;
    index_t     older_index;
    index_t     newer_index;
    logic [1:0] seen_count;
    logic       strip_parity;
  } asm_state_t;

  typedef struct packed {
    logic [1:0]          mode;
    logic                start_req;
    logic [VIN_BITS-1:0] vertex_index;
    word_t               vertex_offset;
  } vtx_item_t;

  typedef struct packed {
    word_t corner_a;
    word_t corner_b;
    word_t corner_c;
  } tri_t;

  // Keep the low INDEX_BITS bits of an incoming index (zero-extended if wider)
  function automatic index_t take_index(logic [VIN_BITS-1:0] v);
    logic [WORD_BITS-1:0] w;
    w = WORD_BITS'(v);
    return w[INDEX_BITS-1:0];
  endfunction

  // Corner = index + offset, 32-bit wrap
  function automatic word_t add_offset(index_t idx, word_t off);
    return WORD_BITS'(idx) + off;
  endfunction

endpackage

### sv/tpa_if.sv
// ----------------------------------------------------------------------------
// tpa_if - valid/ready channels of the triangle primitive assembler
// Vertex input channel and triangle result channel.
// ----------------------------------------------------------------------------
interface tpa_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic                          start_req;
  logic [tpa_pkg::VIN_BITS-1:0]  vertex_index;
  logic [tpa_pkg::WORD_BITS-1:0] vertex_offset;

  modport source (output valid, mode, start_req, vertex_index, vertex_offset, input ready);
  modport sink   (input valid, mode, start_req, vertex_index, vertex_offset, output ready);
endinterface

interface tpa_out_if;
  logic                          valid;
  logic                          ready;
  logic [tpa_pkg::WORD_BITS-1:0] corner_a;
  logic [tpa_pkg::WORD_BITS-1:0] corner_b;
  logic [tpa_pkg::WORD_BITS-1:0] corner_c;

  modport source (output valid, corner_a, corner_b, corner_c, input ready);
  modport sink   (input valid, corner_a, corner_b, corner_c, output ready);
endinterface

### sv/tpa_step.sv
// ----------------------------------------------------------------------------
// tpa_step - one assembly step
// Next assembler state and the optional triangle for one vertex item.
// ----------------------------------------------------------------------------
module tpa_step (
  input  tpa_pkg::asm_state_t cur,
  input  tpa_pkg::vtx_item_t  item,
  output tpa_pkg::asm_state_t nxt,
  output logic                emit,
  output tpa_pkg::tri_t       tri_out
);

  tpa_pkg::asm_state_t base;
  tpa_pkg::index_t     idx;
  tpa_pkg::index_t     ca, cb, cc;

  always_comb begin
    idx  = tpa_pkg::take_index(item.vertex_index);
    base = cur;
    if (item.start_req) begin
      base.seen_count   = tpa_pkg::SEEN_NONE;
      base.strip_parity = 1'b0;
    end
    nxt  = base;
    emit = 1'b0;
    ca   = base.older_index;
    cb   = base.newer_index;
    cc   = idx;

    case (item.mode)
      tpa_pkg::MODE_LIST: begin
        case (base.seen_count)
          tpa_pkg::SEEN_NONE: begin
            nxt.older_index = idx;
            nxt.seen_count  = tpa_pkg::SEEN_ONE;
          end
          tpa_pkg::SEEN_ONE: begin
            nxt.newer_index = idx;
            nxt.seen_count  = tpa_pkg::SEEN_TWO;
          end
          default: begin
            emit           = 1'b1;
            nxt.seen_count = tpa_pkg::SEEN_NONE;
          end
        endcase
      end
      tpa_pkg::MODE_FAN: begin
        ca = base.fan_anchor;
        case (base.seen_count)
          tpa_pkg::SEEN_NONE: begin
            nxt.fan_anchor = idx;
            nxt.seen_count = tpa_pkg::SEEN_ONE;
          end
          tpa_pkg::SEEN_ONE: begin
            nxt.newer_index = idx;
            nxt.seen_count  = tpa_pkg::SEEN_TWO;
          end
          default: begin
            emit            = 1'b1;
            nxt.newer_index = idx;
            nxt.seen_count  = tpa_pkg::SEEN_TWO;
          end
        endcase
      end
      tpa_pkg::MODE_STRIP: begin
        case (base.seen_count)
          tpa_pkg::SEEN_NONE: begin
            nxt.older_index = idx;
            nxt.seen_count  = tpa_pkg::SEEN_ONE;
          end
          tpa_pkg::SEEN_ONE: begin
            nxt.newer_index = idx;
            nxt.seen_count  = tpa_pkg::SEEN_TWO;
          end
          default: begin
            emit = 1'b1;
            // odd strip triangles swap the last two corners
            if (base.strip_parity) begin
              cb = idx;
              cc = base.newer_index;
            end
            nxt.older_index  = base.newer_index;
            nxt.newer_index  = idx;
            nxt.strip_parity = ~base.strip_parity;
            nxt.seen_count   = tpa_pkg::SEEN_TWO;
          end
        endcase
      end
      default: begin
        // undefined mode: item dropped, state untouched even on start
        nxt = cur;
      end
    endcase

    tri_out.corner_a = tpa_pkg::add_offset(ca, item.vertex_offset);
    tri_out.corner_b = tpa_pkg::add_offset(cb, item.vertex_offset);
    tri_out.corner_c = tpa_pkg::add_offset(cc, item.vertex_offset);
  end

endmodule

### sv/triangle_primitive_assembler.sv
// ----------------------------------------------------------------------------
// triangle_primitive_assembler - list / fan / strip to triangle list
// Turns a stream of vertex indices into triangles of offset corner indices.
// ----------------------------------------------------------------------------
// Path: a triangle passes the input register, then the result register, before
//   it is valid on out_ch and can transfer there.
// Throughput: 1 vertex item per cycle; only a stalled result register holding a
//   triangle while the next item also completes one stops the input.
// Reset: synchronous, active-low rst_n clears both stage valids and the
//   assembler state (counts, parity, stored indices) to zero.
// ----------------------------------------------------------------------------
module triangle_primitive_assembler (
  input  logic      clk,
  input  logic      rst_n,
  tpa_in_if.sink    in_ch,
  tpa_out_if.source out_ch
);

  // Input register: one vertex item
  logic                s1_valid_r;
  tpa_pkg::vtx_item_t  s1_item_r;

  // Assembler state, advanced when the item in s1 retires
  tpa_pkg::asm_state_t state_r;
  tpa_pkg::asm_state_t state_nxt;

  // Result register
  logic                out_valid_r;
  tpa_pkg::tri_t       out_tri_r;

  logic                step_emit;
  tpa_pkg::tri_t       step_tri;
  logic                out_free;
  logic                s1_adv;
  logic                in_xfer;

  tpa_step u_step (
    .cur     (state_r),
    .item    (s1_item_r),
    .nxt     (state_nxt),
    .emit    (step_emit),
    .tri_out (step_tri)
  );

  // The result register frees up this cycle if empty or its transfer completes.
  assign out_free = !out_valid_r || out_ch.ready;
  // Items that build no triangle retire regardless of the output side.
  assign s1_adv   = s1_valid_r && (out_free || !step_emit);
  assign in_xfer  = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.mode          <= in_ch.mode;
      s1_item_r.start_req     <= in_ch.start_req;
      s1_item_r.vertex_index  <= in_ch.vertex_index;
      s1_item_r.vertex_offset <= in_ch.vertex_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && step_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_adv && step_emit) begin
      out_tri_r <= step_tri;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.corner_a = out_tri_r.corner_a;
  assign out_ch.corner_b = out_tri_r.corner_b;
  assign out_ch.corner_c = out_tri_r.corner_c;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // The window count never reaches the unused code
  a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.seen_count != tpa_pkg::SEEN_BAD)
    else $error("seen_count reached unused code");

  // An empty input register always takes a new item
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ch.ready)
    else $error("input stalled with empty stage");

  // A blocked triangle keeps its item and the state in place
  a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(state_r)))
    else $error("blocked item lost or state moved");

  // No result is presented right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

endmodule
